FILE: sv/gcb_pkg.sv
// ----------------------------------------------------------------------------
// gcb_pkg
// shared constants for the great circle bearing pipeline
// ----------------------------------------------------------------------------
`default_nettype none

package gcb_pkg;

    localparam int CORDIC_STAGES = 24;
    localparam int TAB_LEN       = 40;

    // rotation datapath width (q1.30 plus growth headroom)
    localparam int RW = 34;
    // vectoring datapath width
    localparam int VW = 36;

    // atan(2^-i) as a 32-bit binary angle
    localparam logic [31:0] ATAN_TAB [0:TAB_LEN-1] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722,
        32'd20861, 32'd10430, 32'd5215, 32'd2608, 32'd1304,
        32'd652, 32'd326, 32'd163, 32'd81, 32'd41, 32'd20,
        32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0, 32'd0, 32'd0,
        32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0
    };

    localparam logic signed [RW-1:0] GAIN_Q30 = 34'sd652032874;
    localparam logic signed [RW-1:0] ONE_Q30  = 34'sd1073741824;

    // round(2^49 / 140625): degree-to-binary-angle reciprocal, 2^-25 scaled
    localparam logic [31:0] BAM_RECIP = 32'd4003199669;
    localparam logic [51:0] DIV_HALF  = 52'd140625;
    localparam logic [18:0] DIV_D     = 19'd281250;
    localparam logic [15:0] BRG_SCALE = 16'd36000;

endpackage

`default_nettype wire

FILE: sv/gcb_cordic_rot.sv
// ----------------------------------------------------------------------------
// gcb_cordic_rot
// pipelined cordic rotation, binary angle in, clamped q1.30 sin and cos out
// ----------------------------------------------------------------------------
`default_nettype none

module gcb_cordic_rot
(
    input  wire logic               clk,
    input  wire logic               en,
    input  wire logic [31:0]        angle,
    output logic signed [31:0]      sin_q30,
    output logic signed [31:0]      cos_q30
);

    localparam int N  = gcb_pkg::CORDIC_STAGES;
    localparam int RW = gcb_pkg::RW;

    logic signed [RW-1:0] x_reg [0:N];
    logic signed [RW-1:0] y_reg [0:N];
    logic signed [RW-1:0] z_reg [0:N];
    logic                 flip_reg [0:N];

    logic [31:0] quad_sum;
    logic [31:0] t_next;
    logic        flip_next;

    // fold into -90..90 degrees, undo by negation at the end
    always_comb
    begin
        quad_sum  = angle + 32'h4000_0000;
        flip_next = quad_sum[31];
        t_next    = flip_next ? (angle + 32'h8000_0000) : angle;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= gcb_pkg::GAIN_Q30;
            y_reg[0]    <= '0;
            z_reg[0]    <= RW'(signed'(t_next));
            flip_reg[0] <= flip_next;
        end
    end

    for (genvar i = 0; i < N; i++)
    begin : g_iter
        logic signed [RW-1:0] xs;
        logic signed [RW-1:0] ys;
        logic signed [RW-1:0] at;

        assign xs = x_reg[i] >>> i;
        assign ys = y_reg[i] >>> i;
        assign at = signed'({{(RW-32){1'b0}}, gcb_pkg::ATAN_TAB[i]});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!z_reg[i][RW-1])
                begin
                    x_reg[i+1] <= x_reg[i] - ys;
                    y_reg[i+1] <= y_reg[i] + xs;
                    z_reg[i+1] <= z_reg[i] - at;
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + ys;
                    y_reg[i+1] <= y_reg[i] - xs;
                    z_reg[i+1] <= z_reg[i] + at;
                end
                flip_reg[i+1] <= flip_reg[i];
            end
        end
    end

    logic signed [RW-1:0] xc;
    logic signed [RW-1:0] yc;
    logic signed [RW-1:0] xf;
    logic signed [RW-1:0] yf;

    always_comb
    begin
        xc = x_reg[N];
        yc = y_reg[N];
        if (xc > gcb_pkg::ONE_Q30)
            xc = gcb_pkg::ONE_Q30;
        else if (xc < -gcb_pkg::ONE_Q30)
            xc = -gcb_pkg::ONE_Q30;
        if (yc > gcb_pkg::ONE_Q30)
            yc = gcb_pkg::ONE_Q30;
        else if (yc < -gcb_pkg::ONE_Q30)
            yc = -gcb_pkg::ONE_Q30;
        xf = flip_reg[N] ? -xc : xc;
        yf = flip_reg[N] ? -yc : yc;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cos_q30 <= xf[31:0];
            sin_q30 <= yf[31:0];
        end
    end

endmodule

`default_nettype wire

FILE: sv/gcb_cordic_vec.sv
// ----------------------------------------------------------------------------
// gcb_cordic_vec
// pipelined cordic vectoring, atan2(y, x) as a 32-bit binary angle
// ----------------------------------------------------------------------------
`default_nettype none

module gcb_cordic_vec
(
    input  wire logic               clk,
    input  wire logic               en,
    input  wire logic signed [31:0] y_in,
    input  wire logic signed [32:0] x_in,
    output logic [31:0]             angle
);

    localparam int N  = gcb_pkg::CORDIC_STAGES;
    localparam int VW = gcb_pkg::VW;

    logic signed [VW-1:0] x_reg [0:N];
    logic signed [VW-1:0] y_reg [0:N];
    logic [31:0]          z_reg [0:N];
    logic                 zero_reg [0:N];

    logic signed [VW-1:0] xe;
    logic signed [VW-1:0] ye;

    assign xe = VW'(x_in);
    assign ye = VW'(y_in);

    // left half plane: rotate by 180 degrees first
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zero_reg[0] <= (x_in == '0) && (y_in == '0);
            if (x_in[32])
            begin
                x_reg[0] <= -xe;
                y_reg[0] <= -ye;
                z_reg[0] <= 32'h8000_0000;
            end
            else
            begin
                x_reg[0] <= xe;
                y_reg[0] <= ye;
                z_reg[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < N; i++)
    begin : g_iter
        logic signed [VW-1:0] xs;
        logic signed [VW-1:0] ys;

        assign xs = x_reg[i] >>> i;
        assign ys = y_reg[i] >>> i;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!y_reg[i][VW-1])
                begin
                    x_reg[i+1] <= x_reg[i] + ys;
                    y_reg[i+1] <= y_reg[i] - xs;
                    z_reg[i+1] <= z_reg[i] + gcb_pkg::ATAN_TAB[i];
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] - ys;
                    y_reg[i+1] <= y_reg[i] + xs;
                    z_reg[i+1] <= z_reg[i] - gcb_pkg::ATAN_TAB[i];
                end
                zero_reg[i+1] <= zero_reg[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            angle <= zero_reg[N] ? '0 : z_reg[N];
    end

endmodule

`default_nettype wire

FILE: sv/great_circle_bearing_core.sv
// ----------------------------------------------------------------------------
// great_circle_bearing_core
// initial great-circle bearing between two lat/lon points, fully pipelined
// ----------------------------------------------------------------------------
//
//  channel  | signals                                        | dir
//  ---------+------------------------------------------------+-----
//  input    | in_valid, in_stall, start_lat, start_lon,      | in
//           | end_lat, end_lon                               |
//  output   | out_valid, out_stall, bearing_centideg         | out
//
//  one beat enters per cycle while in_stall is low; the beat passes through
//  the two unrolled cordic pipelines in series
//  reset clears only the valid bits that travel with the data
//  one enable moves every stage; when the output beat is held by out_stall
//  the whole pipe freezes and in_stall is raised, so nothing is lost
// ----------------------------------------------------------------------------
`default_nettype none

module great_circle_bearing_core
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic signed [24:0] start_lat,
    input  wire logic signed [25:0] start_lon,
    input  wire logic signed [24:0] end_lat,
    input  wire logic signed [25:0] end_lon,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [15:0]             bearing_centideg
);

    localparam int N   = gcb_pkg::CORDIC_STAGES;
    localparam int LAT = 2 * N + 12;

    logic en;
    logic vld_reg [0:LAT-1];

    // pipe advances unless the finished beat is being held
    assign en        = !(vld_reg[LAT-1] && out_stall);
    assign in_stall  = !en;
    assign out_valid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < LAT; k++)
                vld_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            for (int k = 1; k < LAT; k++)
                vld_reg[k] <= vld_reg[k-1];
        end
    end

    // ------------------------------------------------------------------
    // degrees*1e5 to binary angle: round(|v| * 2^32 / 36e6), sign applied
    // three lanes: start lat, end lat, longitude difference
    // ------------------------------------------------------------------
    logic signed [26:0] ang_v [0:2];

    assign ang_v[0] = 27'(start_lat);
    assign ang_v[1] = 27'(end_lat);
    assign ang_v[2] = 27'(end_lon) - 27'(start_lon);

    logic [31:0] bam [0:2];

    for (genvar k = 0; k < 3; k++)
    begin : g_conv
        logic [26:0] m1_reg;
        logic        neg1_reg;
        logic [26:0] m2_reg;
        logic        neg2_reg;
        logic [58:0] prod_reg;
        logic [26:0] m3_reg;
        logic        neg3_reg;
        logic [33:0] qe_reg;
        logic [52:0] qm_reg;
        logic [31:0] bam_reg;

        logic [59:0] rnd;
        logic [33:0] qe_next;
        logic [51:0] p_num;
        logic signed [54:0] rem;
        logic [33:0] q_fix;
        logic [31:0] bam_next;

        always_comb
        begin
            rnd      = {1'b0, prod_reg} + 60'd16777216;
            qe_next  = rnd[58:25];
            p_num    = {m3_reg, 25'b0} + gcb_pkg::DIV_HALF;
            rem      = signed'({3'b000, p_num}) - signed'({2'b00, qm_reg});
            if (rem[54])
                q_fix = qe_reg - 34'd1;
            else if (rem >= signed'({36'd0, gcb_pkg::DIV_D}))
                q_fix = qe_reg + 34'd1;
            else
                q_fix = qe_reg;
            bam_next = neg3_reg ? (32'd0 - q_fix[31:0]) : q_fix[31:0];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                neg1_reg <= ang_v[k][26];
                m1_reg   <= ang_v[k][26] ? (27'd0 - ang_v[k]) : ang_v[k];
                prod_reg <= 59'(m1_reg) * 59'(gcb_pkg::BAM_RECIP);
                m2_reg   <= m1_reg;
                neg2_reg <= neg1_reg;
                qe_reg   <= qe_next;
                qm_reg   <= 53'(qe_next) * 53'(gcb_pkg::DIV_D);
                m3_reg   <= m2_reg;
                neg3_reg <= neg2_reg;
                bam_reg  <= bam_next;
            end
        end

        assign bam[k] = bam_reg;
    end

    // ------------------------------------------------------------------
    // sin and cos of the three angles
    // ------------------------------------------------------------------
    logic signed [31:0] s1, c1, s2, c2, sd, cd;

    gcb_cordic_rot u_rot_lat1
    (
        .clk     (clk),
        .en      (en),
        .angle   (bam[0]),
        .sin_q30 (s1),
        .cos_q30 (c1)
    );

    gcb_cordic_rot u_rot_lat2
    (
        .clk     (clk),
        .en      (en),
        .angle   (bam[1]),
        .sin_q30 (s2),
        .cos_q30 (c2)
    );

    gcb_cordic_rot u_rot_dlon
    (
        .clk     (clk),
        .en      (en),
        .angle   (bam[2]),
        .sin_q30 (sd),
        .cos_q30 (cd)
    );

    // ------------------------------------------------------------------
    // atan2 operands, products floored back to q1.30
    // num = sd*c2 ; den = c1*s2 - (s1*c2)*cd
    // ------------------------------------------------------------------
    logic signed [63:0] num_p_reg;
    logic signed [63:0] a_p_reg;
    logic signed [63:0] t_p_reg;
    logic signed [31:0] cd1_reg;

    logic signed [31:0] num2_reg;
    logic signed [63:0] a2_reg;
    logic signed [63:0] b2_reg;

    logic signed [31:0] num3_reg;
    logic signed [32:0] den3_reg;

    logic signed [63:0] num_sh;
    logic signed [63:0] t_sh;
    logic signed [63:0] diff;
    logic signed [63:0] den_sh;

    always_comb
    begin
        num_sh = num_p_reg >>> 30;
        t_sh   = t_p_reg >>> 30;
        diff   = a2_reg - b2_reg;
        den_sh = diff >>> 30;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_p_reg <= 64'(sd) * 64'(c2);
            a_p_reg   <= 64'(c1) * 64'(s2);
            t_p_reg   <= 64'(s1) * 64'(c2);
            cd1_reg   <= cd;

            num2_reg  <= num_sh[31:0];
            a2_reg    <= a_p_reg;
            b2_reg    <= 64'(signed'(t_sh[31:0])) * 64'(cd1_reg);

            num3_reg  <= num2_reg;
            den3_reg  <= den_sh[32:0];
        end
    end

    // ------------------------------------------------------------------
    // bearing angle and scaling to hundredths of a degree
    // ------------------------------------------------------------------
    logic [31:0] brg_bam;

    gcb_cordic_vec u_vec
    (
        .clk   (clk),
        .en    (en),
        .y_in  (num3_reg),
        .x_in  (den3_reg),
        .angle (brg_bam)
    );

    logic [47:0] brg_prod;

    assign brg_prod = 48'(brg_bam) * 48'(gcb_pkg::BRG_SCALE);

    always_ff @(posedge clk)
    begin
        if (en)
            bearing_centideg <= brg_prod[47:32];
    end

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// bench for great_circle_bearing_core: directed and random point pairs go in,
// each bearing beat is checked against a fixed-point cordic predictor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    localparam int  WATCHDOG_LIMIT = 2000;
    localparam int  DRAIN_CYCLES   = 80;
    localparam longint ONE_FIX     = 64'sd1073741824;
    localparam longint GAIN_FIX    = 64'sd652032874;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic signed [24:0] start_lat;
    logic signed [25:0] start_lon;
    logic signed [24:0] end_lat;
    logic signed [25:0] end_lon;
    logic               out_valid;
    logic               out_stall;
    logic [15:0]        bearing_centideg;

    logic [15:0] bearing_queue [$];
    int          fail_count  = 0;
    int          idle_cycles = 0;
    bit          timed_out   = 1'b0;

    great_circle_bearing_core i_dut
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .start_lat        (start_lat),
        .start_lon        (start_lon),
        .end_lat          (end_lat),
        .end_lon          (end_lon),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .bearing_centideg (bearing_centideg)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // floor shift right for signed values
    function automatic longint floor_shr(longint v, int s);
        return v >>> s;
    endfunction

    // 1e-5 degree to 32-bit binary angle, half away from zero
    function automatic logic [31:0] deg_to_angle(longint v);
        longint unsigned mag;
        longint unsigned q;
        logic [31:0]     r;
        mag = (v < 0) ? longint'(-v) : longint'(v);
        q   = (mag * 64'd4294967296 + 64'd18000000) / 64'd36000000;
        r   = q[31:0];
        if (v < 0)
            r = 32'd0 - r;
        return r;
    endfunction

    function automatic longint clip_unit(longint v);
        if (v > ONE_FIX)
            return ONE_FIX;
        if (v < -ONE_FIX)
            return -ONE_FIX;
        return v;
    endfunction

    // rotation cordic; results in q1.30
    task automatic rotate_angle(input logic [31:0] ang, output longint s,
                                output longint c);
        logic [31:0] t;
        bit          flip;
        longint      x;
        longint      y;
        longint      z;
        longint      nx;
        longint      ny;
        t    = ang;
        flip = ((t + 32'h40000000) & 32'h80000000) != 0;
        x    = GAIN_FIX;
        y    = 0;
        if (flip)
            t = t + 32'h80000000;
        z = longint'($signed(t));
        for (int i = 0; i < gcb_pkg::CORDIC_STAGES && i < gcb_pkg::TAB_LEN; i++)
        begin
            if (z >= 0)
            begin
                nx = x - floor_shr(y, i);
                ny = y + floor_shr(x, i);
                z  = z - longint'(gcb_pkg::ATAN_TAB[i]);
            end
            else
            begin
                nx = x + floor_shr(y, i);
                ny = y - floor_shr(x, i);
                z  = z + longint'(gcb_pkg::ATAN_TAB[i]);
            end
            x = nx;
            y = ny;
        end
        x = clip_unit(x);
        y = clip_unit(y);
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        s = y;
        c = x;
    endtask

    // vectoring cordic; binary angle that wraps modulo a full turn
    function automatic logic [31:0] vector_angle(longint y, longint x);
        logic [31:0] z;
        longint      nx;
        longint      ny;
        z = 32'd0;
        if (x == 0 && y == 0)
            return 32'd0;
        if (x < 0)
        begin
            x = -x;
            y = -y;
            z = 32'h80000000;
        end
        for (int i = 0; i < gcb_pkg::CORDIC_STAGES && i < gcb_pkg::TAB_LEN; i++)
        begin
            if (y >= 0)
            begin
                nx = x + floor_shr(y, i);
                ny = y - floor_shr(x, i);
                z  = z + gcb_pkg::ATAN_TAB[i];
            end
            else
            begin
                nx = x - floor_shr(y, i);
                ny = y + floor_shr(x, i);
                z  = z - gcb_pkg::ATAN_TAB[i];
            end
            x = nx;
            y = ny;
        end
        return z;
    endfunction

    task automatic predict_bearing(input logic signed [24:0] lat1,
                                   input logic signed [25:0] lon1,
                                   input logic signed [24:0] lat2,
                                   input logic signed [25:0] lon2,
                                   output logic [15:0] brg);
        longint          s1, c1, s2, c2, sd, cd, num, den, a, b;
        logic [31:0]     ang;
        longint unsigned wide;
        rotate_angle(deg_to_angle(longint'(lat1)), s1, c1);
        rotate_angle(deg_to_angle(longint'(lat2)), s2, c2);
        rotate_angle(deg_to_angle(longint'(lon2) - longint'(lon1)), sd, cd);
        num  = floor_shr(sd * c2, 30);
        a    = c1 * s2;
        b    = floor_shr(s1 * c2, 30) * cd;
        den  = floor_shr(a - b, 30);
        ang  = vector_angle(num, den);
        wide = (longint'(ang) * 64'd36000) >> 32;
        brg  = wide[15:0];
    endtask

    // drive one point pair, hold it until the core takes the beat
    task automatic send_pair(input logic signed [24:0] lat1,
                             input logic signed [25:0] lon1,
                             input logic signed [24:0] lat2,
                             input logic signed [25:0] lon2);
        logic [15:0] brg;
        int          gap;
        gap = $urandom_range(0, 7);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap)
                @(posedge clk);
        end
        predict_bearing(lat1, lon1, lat2, lon2, brg);
        in_valid  <= 1'b1;
        start_lat <= lat1;
        start_lon <= lon1;
        end_lat   <= lat2;
        end_lon   <= lon2;
        bearing_queue.insert(bearing_queue.size(), brg);
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // receiver: stall for a random count per beat, check each taken beat
    initial
    begin
        logic [15:0] want;
        int          hold;
        out_stall <= 1'b1;
        @(posedge rst_n);
        forever
        begin
            hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
            if (hold != 0)
            begin
                out_stall <= 1'b1;
                repeat (hold)
                    @(posedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
            if (bearing_queue.size() == 0)
            begin
                $error("bearing_centideg: beat with none expected, actual %0d",
                       bearing_centideg);
                fail_count++;
            end
            else
            begin
                want = bearing_queue.pop_front();
                if (bearing_centideg !== want)
                begin
                    $error("bearing_centideg: expected %0d, actual %0d",
                           want, bearing_centideg);
                    fail_count++;
                end
            end
        end
    end

    // watchdog on cycles without any accepted beat
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT && !timed_out)
        begin
            timed_out = 1'b1;
            $display("FAILED: results differ");
            $finish;
        end
    end

    function automatic logic signed [24:0] rand_lat();
        return 25'($signed($urandom_range(0, 18000000)) - 9000000);
    endfunction

    function automatic logic signed [25:0] rand_lon();
        return 26'($signed($urandom_range(0, 36000000)) - 18000000);
    endfunction

    // field extremes, poles, date line and degenerate pairs
    task automatic test_directed();
        send_pair(25'sd0, 26'sd0, 25'sd0, 26'sd0);
        send_pair(25'sd0, 26'sd0, 25'sd100, 26'sd0);
        send_pair(25'sd0, 26'sd0, 25'sd0, 26'sd100);
        send_pair(25'sd0, 26'sd0, -25'sd100, 26'sd0);
        send_pair(25'sd0, 26'sd0, 25'sd0, -26'sd100);
        send_pair(25'sd0, 26'sd0, -25'sd1, -26'sd1);
        send_pair(25'sd9000000, 26'sd0, -25'sd9000000, 26'sd0);
        send_pair(-25'sd9000000, 26'sd18000000, 25'sd9000000, -26'sd18000000);
        send_pair(25'sd9000000, 26'sd0, 25'sd9000000, 26'sd5000000);
        send_pair(25'sd0, -26'sd18000000, 25'sd0, 26'sd18000000);
        send_pair(25'sd0, 26'sd17999999, 25'sd0, -26'sd17999999);
        // out-of-range coordinates wrap around
        send_pair(25'h0FFFFFF, 26'h1FFFFFF, 25'h1000000, 26'h2000000);
        send_pair(25'h1000000, 26'h2000000, 25'h0FFFFFF, 26'h1FFFFFF);
        send_pair(25'h1FFFFFF, 26'h3FFFFFF, 25'h0AAAAAA, 26'h1555555);
        send_pair(25'h0555555, 26'h2AAAAAA, 25'h1555555, 26'h0AAAAAA);
        send_pair(25'sd4000000, 26'sd1000000, 25'sd4000000, 26'sd1000000);
        send_pair(25'sd5250000, -26'sd100000, 25'sd4880000, 26'sd235000);
        send_pair(-25'sd3386000, 26'sd15121000, 25'sd5150000, -26'sd12000);
    endtask

    // uniform valid coordinates
    task automatic test_random_valid(int count);
        for (int n = 0; n < count; n++)
            send_pair(rand_lat(), rand_lon(), rand_lat(), rand_lon());
    endtask

    // nearby points, where the atan2 operands are tiny
    task automatic test_random_close(int count);
        logic signed [24:0] lat;
        logic signed [25:0] lon;
        for (int n = 0; n < count; n++)
        begin
            lat = rand_lat();
            lon = rand_lon();
            send_pair(lat, lon, 25'(lat + $signed($urandom_range(0, 20)) - 10),
                      26'(lon + $signed($urandom_range(0, 20)) - 10));
        end
    endtask

    // any bit pattern, out of range included
    task automatic test_random_raw(int count);
        for (int n = 0; n < count; n++)
            send_pair(25'($urandom), 26'($urandom), 25'($urandom), 26'($urandom));
    endtask

    initial
    begin
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        start_lat   <= '0;
        start_lon   <= '0;
        end_lat     <= '0;
        end_lon     <= '0;
        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_valid(800);
        test_random_close(250);
        test_random_raw(250);
        in_valid <= 1'b0;
        while (bearing_queue.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (fail_count == 0 && bearing_queue.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
